// ----- rtl/mouse_packet_cursor_tracker_assert.svh -----
// Assertion helpers for the cursor tracker.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MPCT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that cons holds in the cycle after ante holds.
`define MPCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/mpct_pkg.sv -----
`default_nettype none

package mpct_pkg;

  // Grid size defaults
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CELL_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BTN_W  = 3;

  // Toggles per completed packet: old cell, new cell, one per changed button
  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Byte positions inside a packet
  localparam logic [1:0] POS_BUTTONS = 2'd0;
  localparam logic [1:0] POS_DX      = 2'd1;
  localparam logic [1:0] POS_DY      = 2'd2;

  // Signed width for position plus delta (coordinate up to 127, delta -128 to +127)
  localparam int SUM_W = 10;

endpackage

`default_nettype wire

// ----- rtl/mouse_packet_cursor_tracker.sv -----
// Mouse packet cursor tracker.
// Input channel (in_valid_i/in_ready_o): one controller read per item, the
// aux flag and the data byte. Unflagged bytes are dropped. Flagged bytes
// form three-byte packets (buttons, X delta, Y delta).
// Output channel (out_valid_o/out_ready_i): one highlight toggle per item,
// with the cell index, the cursor position after the packet and a flag on
// the last toggle of the packet. A completed packet gives 2 to 5 items: old
// cell, new cell, and one at the new cell per changed button.
// Path: a packet's third byte goes from the input register to the toggle
// sequencer, whose first toggle then loads the output register; the rest
// follow one per cycle while the receiver takes them. Other bytes never wait
// on the sequencer; a packet's last byte waits in the input register until
// the single toggle sequencer that feeds the output register is free.
// Reset: cursor at the grid center, packet position and buttons cleared,
// both channels empty.
// A stalled receiver holds the output and sequencer; once a packet's last
// byte fills the input register, in_ready_o drops until the output drains.

`default_nettype none

`include "mouse_packet_cursor_tracker_assert.svh"

module mouse_packet_cursor_tracker #(
  parameter int COLS = mpct_pkg::COLS_DEF,
  parameter int ROWS = mpct_pkg::ROWS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        aux_data_ready_i,
  input  wire logic [mpct_pkg::BYTE_W-1:0] data_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [mpct_pkg::CELL_W-1:0]      cell_index_o,
  output logic [mpct_pkg::COL_W-1:0]       cursor_col_o,
  output logic [mpct_pkg::ROW_W-1:0]       cursor_row_o,
  output logic                             last_of_run_o
);
  import mpct_pkg::*;

  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);
  localparam logic [15:0] COLS16 = 16'(COLS);
  localparam logic [SUM_W-1:0] COL_TOP = SUM_W'(COLS - 1);
  localparam logic [SUM_W-1:0] ROW_TOP = SUM_W'(ROWS - 1);
  localparam logic [CW-1:0] COL_RST = CW'(COLS / 2);
  localparam logic [RW-1:0] ROW_RST = RW'(ROWS / 2);
  localparam logic [15:0] CELL_RST16 = 16'((ROWS / 2) * COLS + COLS / 2);
  localparam logic [CELL_W-1:0] CELL_RST = CELL_RST16[CELL_W-1:0];

  // Input register
  logic              in_valid_q;
  logic              aux_q;
  logic [BYTE_W-1:0] byte_q;

  // Packet and cursor state
  logic [1:0]        pos_q;
  logic [BYTE_W-1:0] b0_q, b1_q;
  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row_q;
  logic [CELL_W-1:0] cur_cell_q;
  logic [BTN_W-1:0]  btn_q;

  // Toggle sequencer
  logic [CNT_W-1:0]  run_cnt_q;
  logic              run_first_q;
  logic [CELL_W-1:0] run_old_cell_q, run_new_cell_q;
  logic [CW-1:0]     run_col_q;
  logic [RW-1:0]     run_row_q;

  // Output register
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_last_q;

  logic              in_final, run_free, adv, out_load, emit;
  logic signed [SUM_W-1:0] col_sum, row_sum;
  logic [CW-1:0]     new_col;
  logic [RW-1:0]     new_row;
  logic [15:0]       new_cell16;
  logic [BTN_W-1:0]  btn_diff;
  logic [CNT_W-1:0]  run_total;

  // Handshake between stages
  assign in_final   = aux_q && (pos_q >= POS_DY);
  assign out_load   = !out_valid_q || out_ready_i;
  assign emit       = out_load && (run_cnt_q != '0);
  assign run_free   = (run_cnt_q == '0) || ((run_cnt_q == CNT_W'(1)) && out_load);
  assign adv        = in_valid_q && (!in_final || run_free);
  assign in_ready_o = !in_valid_q || adv;

  // Move cursor by the packet deltas and saturate to the grid
  always_comb begin
    col_sum = $signed({{(SUM_W-CW){1'b0}}, col_q})
            + $signed({{(SUM_W-BYTE_W){b1_q[BYTE_W-1]}}, b1_q});
    row_sum = $signed({{(SUM_W-RW){1'b0}}, row_q})
            - $signed({{(SUM_W-BYTE_W){byte_q[BYTE_W-1]}}, byte_q});
    if (col_sum < 0) begin
      new_col = '0;
    end else if (col_sum > $signed(COL_TOP)) begin
      new_col = COL_TOP[CW-1:0];
    end else begin
      new_col = col_sum[CW-1:0];
    end
    if (row_sum < 0) begin
      new_row = '0;
    end else if (row_sum > $signed(ROW_TOP)) begin
      new_row = ROW_TOP[RW-1:0];
    end else begin
      new_row = row_sum[RW-1:0];
    end
    new_cell16 = 16'(new_row) * COLS16 + 16'(new_col);
    btn_diff   = b0_q[BTN_W-1:0] ^ btn_q;
    run_total  = CNT_W'(2) + CNT_W'(btn_diff[0]) + CNT_W'(btn_diff[1])
               + CNT_W'(btn_diff[2]);
  end

  // Input register: take an item whenever the stage ahead frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      aux_q  <= aux_data_ready_i;
      byte_q <= data_byte_i;
    end
  end

  // Advance packet position, gather bytes, commit the cursor on the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_BUTTONS;
      b0_q       <= '0;
      b1_q       <= '0;
      col_q      <= COL_RST;
      row_q      <= ROW_RST;
      cur_cell_q <= CELL_RST;
      btn_q      <= '0;
    end else if (adv && aux_q) begin
      if (in_final) begin
        pos_q      <= POS_BUTTONS;
        col_q      <= new_col;
        row_q      <= new_row;
        cur_cell_q <= new_cell16[CELL_W-1:0];
        btn_q      <= b0_q[BTN_W-1:0];
      end else begin
        pos_q <= pos_q + 2'd1;
        if (pos_q == POS_BUTTONS) begin
          b0_q <= byte_q;
        end else begin
          b1_q <= byte_q;
        end
      end
    end
  end

  // Load a toggle run per packet, count it down as items leave
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q   <= '0;
      run_first_q <= 1'b0;
    end else if (adv && in_final) begin
      run_cnt_q   <= run_total;
      run_first_q <= 1'b1;
    end else if (emit) begin
      run_cnt_q   <= run_cnt_q - CNT_W'(1);
      run_first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_final) begin
      run_old_cell_q <= cur_cell_q;
      run_new_cell_q <= new_cell16[CELL_W-1:0];
      run_col_q      <= new_col;
      run_row_q      <= new_row;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_cell_q <= run_first_q ? run_old_cell_q : run_new_cell_q;
      out_col_q  <= COL_W'(run_col_q);
      out_row_q  <= ROW_W'(run_row_q);
      out_last_q <= (run_cnt_q == CNT_W'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_index_o  = out_cell_q;
  assign cursor_col_o  = out_col_q;
  assign cursor_row_o  = out_row_q;
  assign last_of_run_o = out_last_q;

  // Checks
  `MPCT_ASSERT_SAME(a_run_bound, clk_i, rst_ni, 1'b1, run_cnt_q <= CNT_W'(MAX_RESULTS))
  `MPCT_ASSERT_SAME(a_first_has_two, clk_i, rst_ni, run_first_q, run_cnt_q >= CNT_W'(2))
  `MPCT_ASSERT_NEXT(a_run_no_gap, clk_i, rst_ni, out_valid_q && out_ready_i && !out_last_q,
                    out_valid_q)

endmodule

`default_nettype wire
